// ===== rtl/aar_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aar_pkg: axis-angle rotation matrix shared definitions
// Fixed-point constants, CORDIC angle table, cell payload types for the cells
// and the top level, and the top level's rounding multiply and clamp helpers.
// ----------------------------------------------------------------------------
package aar_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int MOD_STEPS         = 7;
	localparam int SQRT_STEPS        = 32;
	localparam int DIV_STEPS         = 31;
	// front stages, sqrt cells, divide prep, divide cells, sign stage
	localparam int AX_LAT            = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;

	localparam logic [31:0] DEG360_Q16 = 32'd23592960;
	localparam logic [31:0] DEG180_Q16 = 32'd11796480;
	localparam logic [31:0] DEG90_Q16  = 32'd5898240;
	localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

	localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
		30'd4194282,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128,
		30'd64,        30'd32,        30'd16,        30'd8,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	typedef struct packed {
		logic [31:0] v;
		logic        neg;
	} mod_st_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               flip;
	} cordic_st_t;

	typedef struct packed {
		logic [63:0]      rad;
		logic [33:0]      rem;
		logic [31:0]      root;
		logic [2:0][31:0] mg;
		logic [2:0]       neg;
		logic             zero;
	} sqrt_st_t;

	typedef struct packed {
		logic [2:0][31:0] rem;
		logic [2:0][30:0] nlo;
		logic [2:0][30:0] quo;
		logic [31:0]      len;
		logic [2:0]       neg;
		logic             zero;
	} div_st_t;

	// Q1.30 product, round half up
	function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		p = a * b + 68'sd536870912;
		return p[63:30];
	endfunction

	function automatic logic signed [33:0] clamp_q30(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = v;
		if (v > ONE_Q30) r = ONE_Q30;
		if (v < -ONE_Q30) r = -ONE_Q30;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: Rodrigues 3x3 rotation matrix generator
// The angle path is padded to the axis path, so results line up for any
// CORDIC_STAGES up to 32, the depth of the CORDIC angle table.
// Throughput: one transfer per cycle unless out_stall holds a result; the
// square root, divide and CORDIC cell rows take a new item on every advance.
// Reset clears only the valid pipeline; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
	parameter int CORDIC_STAGES = aar_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] angle_degrees,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] c0_r0,
	output logic signed [31:0] c0_r1,
	output logic signed [31:0] c0_r2,
	output logic signed [31:0] c1_r0,
	output logic signed [31:0] c1_r1,
	output logic signed [31:0] c1_r2,
	output logic signed [31:0] c2_r0,
	output logic signed [31:0] c2_r1,
	output logic signed [31:0] c2_r2,
	output logic               zero_axis
);
	import aar_pkg::*;

	localparam int ANG_LAT = MOD_STEPS + 5 + CORDIC_STAGES;
	localparam int DLY     = AX_LAT - ANG_LAT;
	localparam int LAT     = AX_LAT + 3;

	localparam logic [25:0] D360 = 26'(DEG360_Q16);
	localparam logic signed [25:0] D180 = $signed(26'(DEG180_Q16));
	localparam logic signed [25:0] D90  = $signed(26'(DEG90_Q16));

	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv       = !vld_q[LAT-1] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// ---------------- axis path ----------------
	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [31:0]      mx_s1;
	logic [2:0][31:0] mg_s2;
	logic [2:0]       neg_s2;
	logic             zero_s2;
	logic [2:0][31:0] mg_s3;
	logic [2:0][63:0] sq_s3;
	logic [2:0]       neg_s3;
	logic             zero_s3;
	logic [2:0][31:0] mag_c;
	logic [31:0]      mx_c;
	logic [4:0]       sh_c;

	always_comb begin
		mag_c[0] = axis_x[31] ? 32'(-axis_x) : axis_x;
		mag_c[1] = axis_y[31] ? 32'(-axis_y) : axis_y;
		mag_c[2] = axis_z[31] ? 32'(-axis_z) : axis_z;
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) mx_c = mag_c[1];
		if (mag_c[2] > mx_c) mx_c = mag_c[2];
	end

	always_comb begin
		sh_c = '0;
		for (int i = 0; i < 31; i++) begin
			if (mx_s1[i]) sh_c = 5'(30 - i);
		end
		if (mx_s1[31]) sh_c = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag_c;
			neg_s1  <= {axis_z[31], axis_y[31], axis_x[31]};
			mx_s1   <= mx_c;
			for (int k = 0; k < 3; k++) mg_s2[k] <= 32'(mag_s1[k] << sh_c);
			neg_s2  <= neg_s1;
			zero_s2 <= (mx_s1 == '0);
			for (int k = 0; k < 3; k++) sq_s3[k] <= mg_s2[k] * mg_s2[k];
			mg_s3   <= mg_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	sqrt_st_t sq_chain [SQRT_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_chain[0].rad  <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			sq_chain[0].rem  <= '0;
			sq_chain[0].root <= '0;
			sq_chain[0].mg   <= mg_s3;
			sq_chain[0].neg  <= neg_s3;
			sq_chain[0].zero <= zero_s3;
		end
	end

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		aar_sqrt_cell u_cell (
			.clk (clk),
			.en  (adv),
			.d   (sq_chain[g]),
			.q   (sq_chain[g+1])
		);
	end

	div_st_t     dv_chain [DIV_STEPS+1];
	logic [61:0] num_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num_c[k] = {sq_chain[SQRT_STEPS].mg[k], 30'b0}
				+ {31'b0, sq_chain[SQRT_STEPS].root[31:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dv_chain[0].rem[k] <= {1'b0, num_c[k][61:31]};
				dv_chain[0].nlo[k] <= num_c[k][30:0];
				dv_chain[0].quo[k] <= '0;
			end
			dv_chain[0].len  <= sq_chain[SQRT_STEPS].root;
			dv_chain[0].neg  <= sq_chain[SQRT_STEPS].neg;
			dv_chain[0].zero <= sq_chain[SQRT_STEPS].zero;
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		aar_div_cell u_cell (
			.clk (clk),
			.en  (adv),
			.d   (dv_chain[g]),
			.q   (dv_chain[g+1])
		);
	end

	logic signed [33:0] u_s6 [3];
	logic               zero_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				u_s6[k] <= dv_chain[DIV_STEPS].neg[k]
					? -$signed({3'b000, dv_chain[DIV_STEPS].quo[k]})
					: $signed({3'b000, dv_chain[DIV_STEPS].quo[k]});
			end
			zero_s6 <= dv_chain[DIV_STEPS].zero;
		end
	end

	// ---------------- angle path ----------------
	logic signed [31:0] ang_dly_q [DLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_dly_q[0] <= angle_degrees;
			for (int i = 1; i < DLY; i++) ang_dly_q[i] <= ang_dly_q[i-1];
		end
	end

	mod_st_t md_chain [MOD_STEPS+1];

	assign md_chain[0].v   = ang_dly_q[DLY-1][31] ? 32'(-ang_dly_q[DLY-1])
		: ang_dly_q[DLY-1];
	assign md_chain[0].neg = ang_dly_q[DLY-1][31];

	for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
		aar_mod_cell #(.K(MOD_STEPS - 1 - g)) u_cell (
			.clk (clk),
			.en  (adv),
			.d   (md_chain[g]),
			.q   (md_chain[g+1])
		);
	end

	logic [25:0]        r0_c;
	logic signed [25:0] rr_s1;
	logic signed [25:0] r2_c;
	logic               flip_c;
	logic [22:0]        rmag_s2;
	logic               rneg_s2;
	logic               flip_s2;
	logic [49:0]        prod_s3;
	logic               rneg_s3;
	logic               flip_s3;
	logic [30:0]        rm_c;

	always_comb begin
		// floor modulo: a negative angle with nonzero remainder wraps up
		r0_c = (md_chain[MOD_STEPS].neg && md_chain[MOD_STEPS].v != '0)
			? 26'(D360 - 26'(md_chain[MOD_STEPS].v)) : 26'(md_chain[MOD_STEPS].v);
		r2_c   = rr_s1;
		flip_c = 1'b0;
		priority if (rr_s1 > D90) begin
			r2_c   = rr_s1 - D180;
			flip_c = 1'b1;
		end else if (rr_s1 < -D90) begin
			r2_c   = rr_s1 + D180;
			flip_c = 1'b1;
		end
		rm_c = 31'((prod_s3 + 50'd131072) >> 18);
	end

	cordic_st_t cr_chain [CORDIC_STAGES+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rr_s1   <= (r0_c >= 26'(D180)) ? $signed(r0_c - D360) : $signed(r0_c);
			rmag_s2 <= r2_c[25] ? 23'(-r2_c) : 23'(r2_c);
			rneg_s2 <= r2_c[25];
			flip_s2 <= flip_c;
			prod_s3 <= rmag_s2 * DEG2RAD_Q32;
			rneg_s3 <= rneg_s2;
			flip_s3 <= flip_s2;
			cr_chain[0].x    <= CORDIC_GAIN_Q30;
			cr_chain[0].y    <= '0;
			cr_chain[0].z    <= rneg_s3 ? -$signed({3'b000, rm_c}) : $signed({3'b000, rm_c});
			cr_chain[0].flip <= flip_s3;
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		aar_cordic_cell #(.IDX(g)) u_cell (
			.clk (clk),
			.en  (adv),
			.d   (cr_chain[g]),
			.q   (cr_chain[g+1])
		);
	end

	logic signed [33:0] c_c;
	logic signed [33:0] s_c;
	logic signed [33:0] c_s5;
	logic signed [33:0] s_s5;
	logic signed [33:0] t_s5;

	always_comb begin
		c_c = clamp_q30(cr_chain[CORDIC_STAGES].x);
		s_c = clamp_q30(cr_chain[CORDIC_STAGES].y);
		if (cr_chain[CORDIC_STAGES].flip) begin
			c_c = -c_c;
			s_c = -s_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5 <= c_c;
			s_s5 <= s_c;
			t_s5 <= ONE_Q30 - c_c;
		end
	end

	// ---------------- matrix assembly ----------------
	// uu order: u0u0, u1u0, u2u0, u1u1, u2u1, u2u2
	logic signed [33:0] uu_s7 [6];
	logic signed [33:0] us_s7 [3];
	logic signed [33:0] c_s7;
	logic signed [33:0] t_s7;
	logic               zero_s7;
	logic signed [33:0] ut_s8 [6];
	logic signed [33:0] us_s8 [3];
	logic signed [33:0] c_s8;
	logic               zero_s8;
	logic signed [33:0] m_c [9];
	logic [31:0]        mat_s9 [9];
	logic               zero_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			uu_s7[0] <= mul_q30(u_s6[0], u_s6[0]);
			uu_s7[1] <= mul_q30(u_s6[1], u_s6[0]);
			uu_s7[2] <= mul_q30(u_s6[2], u_s6[0]);
			uu_s7[3] <= mul_q30(u_s6[1], u_s6[1]);
			uu_s7[4] <= mul_q30(u_s6[2], u_s6[1]);
			uu_s7[5] <= mul_q30(u_s6[2], u_s6[2]);
			for (int k = 0; k < 3; k++) us_s7[k] <= mul_q30(u_s6[k], s_s5);
			c_s7    <= c_s5;
			t_s7    <= t_s5;
			zero_s7 <= zero_s6;
			for (int k = 0; k < 6; k++) ut_s8[k] <= mul_q30(uu_s7[k], t_s7);
			us_s8   <= us_s7;
			c_s8    <= c_s7;
			zero_s8 <= zero_s7;
		end
	end

	always_comb begin
		m_c[0] = ut_s8[0] + c_s8;
		m_c[1] = ut_s8[1] + us_s8[2];
		m_c[2] = ut_s8[2] - us_s8[1];
		m_c[3] = ut_s8[1] - us_s8[2];
		m_c[4] = ut_s8[3] + c_s8;
		m_c[5] = ut_s8[4] + us_s8[0];
		m_c[6] = ut_s8[2] + us_s8[1];
		m_c[7] = ut_s8[4] - us_s8[0];
		m_c[8] = ut_s8[5] + c_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				if (zero_s8) begin
					// identity for a zero-length axis
					mat_s9[k] <= (k == 0 || k == 4 || k == 8) ? ONE_Q30[31:0] : '0;
				end else begin
					mat_s9[k] <= 32'(clamp_q30(m_c[k]));
				end
			end
			zero_s9 <= zero_s8;
		end
	end

	assign c0_r0     = mat_s9[0];
	assign c0_r1     = mat_s9[1];
	assign c0_r2     = mat_s9[2];
	assign c1_r0     = mat_s9[3];
	assign c1_r1     = mat_s9[4];
	assign c1_r2     = mat_s9[5];
	assign c2_r0     = mat_s9[6];
	assign c2_r1     = mat_s9[7];
	assign c2_r2     = mat_s9[8];
	assign zero_axis = zero_s9;

endmodule
`default_nettype wire

// ===== rtl/aar_mod_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aar_mod_cell: angle range reduction cell
// Subtracts 360 degrees scaled by 2^K when the magnitude allows it.
// ----------------------------------------------------------------------------
module aar_mod_cell #(
	parameter int K = 0
) (
	input  logic             clk,
	input  logic             en,
	input  aar_pkg::mod_st_t d,
	output aar_pkg::mod_st_t q
);
	import aar_pkg::*;

	localparam logic [31:0] STEP = 32'(DEG360_Q16 << K);

	mod_st_t nxt;

	always_comb begin
		nxt = d;
		if (d.v >= STEP) nxt.v = d.v - STEP;
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/aar_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aar_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates (x, y) by atan(2^-IDX) toward driving z to zero.
// ----------------------------------------------------------------------------
module aar_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                en,
	input  aar_pkg::cordic_st_t d,
	output aar_pkg::cordic_st_t q
);
	import aar_pkg::*;

	localparam logic signed [33:0] ATAN = {4'b0000, ATAN_Q30[IDX]};

	cordic_st_t         nxt;
	logic signed [33:0] xs;
	logic signed [33:0] ys;

	always_comb begin
		xs  = $signed(d.x) >>> IDX;
		ys  = $signed(d.y) >>> IDX;
		nxt = d;
		if (!d.z[33]) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - ATAN;
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/aar_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aar_sqrt_cell: one digit of the integer square root
// Brings in two radicand bits and resolves one root bit; carries the
// normalized axis along.
// ----------------------------------------------------------------------------
module aar_sqrt_cell (
	input  logic              clk,
	input  logic              en,
	input  aar_pkg::sqrt_st_t d,
	output aar_pkg::sqrt_st_t q
);
	import aar_pkg::*;

	sqrt_st_t    nxt;
	logic [35:0] cand;
	logic [35:0] trial;

	always_comb begin
		cand    = {d.rem, d.rad[63:62]};
		trial   = {2'b00, d.root, 2'b01};
		nxt     = d;
		nxt.rad = {d.rad[61:0], 2'b00};
		if (cand >= trial) begin
			nxt.rem  = 34'(cand - trial);
			nxt.root = {d.root[30:0], 1'b1};
		end else begin
			nxt.rem  = cand[33:0];
			nxt.root = {d.root[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/aar_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aar_div_cell: one quotient bit of three restoring divides
// All three axis lanes share the divisor (the axis length).
// ----------------------------------------------------------------------------
module aar_div_cell (
	input  logic             clk,
	input  logic             en,
	input  aar_pkg::div_st_t d,
	output aar_pkg::div_st_t q
);
	import aar_pkg::*;

	div_st_t     nxt;
	logic [32:0] t;
	logic        ge;

	always_comb begin
		nxt = d;
		for (int k = 0; k < 3; k++) begin
			t  = {d.rem[k], d.nlo[k][30]};
			ge = (t >= {1'b0, d.len});
			nxt.rem[k] = ge ? 32'(t - {1'b0, d.len}) : t[31:0];
			nxt.quo[k] = {d.quo[k][29:0], ge};
			nxt.nlo[k] = {d.nlo[k][29:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule
`default_nettype wire

// ===== sim/tb_axis_angle_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix: self-checking bench for the Rodrigues builder
// Drives angle/axis transfers under several idle and stall mixes, including a
// long output hold-off that backs the pipeline up. A local bit-accurate
// predictor computes each expected 3x3 matrix and the zero-axis flag; results
// are matched in order, field by field.
// ----------------------------------------------------------------------------
module tb_axis_angle_rotation_matrix;

	typedef struct {
		logic signed [31:0] e [9];
		logic               zero;
	} rot_mat_t;

	// floor shift, Q1.30 product with round half up
	function automatic longint prod_q30(longint a, longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint sat_q30(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic rot_mat_t rodrigues(int ang, int ax, int ay, int az);
		longint v [3];
		longint u [3];
		longint m [9];
		longint unsigned mg [3];
		longint unsigned mx, ss, len, q, rm;
		longint r, z, x, y, xn, c, s, t;
		int sh;
		bit flip;
		rot_mat_t o;
		v[0] = ax; v[1] = ay; v[2] = az;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (mg[i] > mx) mx = mg[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 9; i++)
				o.e[i] = (i == 0 || i == 4 || i == 8) ? 32'sd1073741824 : 32'sd0;
			o.zero = 1'b1;
			return o;
		end
		sh = 0;
		while ((mx << sh) < (64'd1 << 30)) sh++;
		ss = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = mg[i] << sh;
			ss = ss + mg[i] * mg[i];
		end
		len = root64(ss);
		for (int i = 0; i < 3; i++) begin
			q = ((mg[i] << 30) + (len >> 1)) / len;
			u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		// reduce to [-90, 90] degrees, folding the rest onto a sign flip
		r = longint'(ang) % 64'sd23592960;
		if (r < 0) r = r + 64'sd23592960;
		if (r >= 64'sd11796480) r = r - 64'sd23592960;
		flip = 1'b0;
		if (r > 64'sd5898240) begin
			r = r - 64'sd11796480;
			flip = 1'b1;
		end else if (r < -64'sd5898240) begin
			r = r + 64'sd11796480;
			flip = 1'b1;
		end
		rm = ((r < 0 ? -r : r) * 64'd74961321 + (64'd1 << 17)) >> 18;
		z = (r < 0) ? -longint'(rm) : longint'(rm);
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < aar_pkg::CORDIC_STAGES_DEF && i < 32; i++) begin
			if (z >= 0) begin
				xn = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(aar_pkg::ATAN_Q30[i]);
			end else begin
				xn = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(aar_pkg::ATAN_Q30[i]);
			end
			x = xn;
		end
		c = sat_q30(x);
		s = sat_q30(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
		t = 64'sd1073741824 - c;
		m[0] = prod_q30(prod_q30(u[0], u[0]), t) + c;
		m[1] = prod_q30(prod_q30(u[1], u[0]), t) + prod_q30(u[2], s);
		m[2] = prod_q30(prod_q30(u[2], u[0]), t) - prod_q30(u[1], s);
		m[3] = prod_q30(prod_q30(u[0], u[1]), t) - prod_q30(u[2], s);
		m[4] = prod_q30(prod_q30(u[1], u[1]), t) + c;
		m[5] = prod_q30(prod_q30(u[2], u[1]), t) + prod_q30(u[0], s);
		m[6] = prod_q30(prod_q30(u[0], u[2]), t) + prod_q30(u[1], s);
		m[7] = prod_q30(prod_q30(u[1], u[2]), t) - prod_q30(u[0], s);
		m[8] = prod_q30(prod_q30(u[2], u[2]), t) + c;
		for (int i = 0; i < 9; i++) o.e[i] = 32'(sat_q30(m[i]));
		o.zero = 1'b0;
		return o;
	endfunction

	class matrix_board;
		rot_mat_t pending_mats [$];
		int       errors;

		function void note_transfer(int ang, int ax, int ay, int az);
			pending_mats.push_back(rodrigues(ang, ax, ay, az));
		endfunction

		task report(string what);
			$display("ERROR @%0t: %s", $time, what);
			errors++;
		endtask

		task check_matrix(rot_mat_t got);
			rot_mat_t exp_m;
			if (pending_mats.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			exp_m = pending_mats.pop_front();
			for (int i = 0; i < 9; i++)
				if (got.e[i] !== exp_m.e[i])
					report($sformatf("c%0d_r%0d got %0d exp %0d", i / 3, i % 3,
						got.e[i], exp_m.e[i]));
			if (got.zero !== exp_m.zero)
				report($sformatf("zero_axis got %b exp %b", got.zero, exp_m.zero));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] angle_degrees;
	logic signed [31:0] axis_x;
	logic signed [31:0] axis_y;
	logic signed [31:0] axis_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2;
	logic               zero_axis;

	matrix_board board = new();
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_req;
	int          quiet_cycles;

	axis_angle_rotation_matrix DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.angle_degrees(angle_degrees), .axis_x(axis_x), .axis_y(axis_y),
		.axis_z(axis_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.c0_r0(c0_r0), .c0_r1(c0_r1), .c0_r2(c0_r2),
		.c1_r0(c1_r0), .c1_r1(c1_r1), .c1_r2(c1_r2),
		.c2_r0(c2_r0), .c2_r1(c2_r1), .c2_r2(c2_r2),
		.zero_axis(zero_axis)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				for (int n = 0; n < 300; n++) @(negedge clk);
				hold_req = 1'b0;
			end
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		rot_mat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.e[0] = c0_r0; got.e[1] = c0_r1; got.e[2] = c0_r2;
			got.e[3] = c1_r0; got.e[4] = c1_r1; got.e[5] = c1_r2;
			got.e[6] = c2_r0; got.e[7] = c2_r1; got.e[8] = c2_r2;
			got.zero = zero_axis;
			board.check_matrix(got);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// called after a falling edge; returns after the one following its transfer
	task automatic send_rotation(int ang, int ax, int ay, int az);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		angle_degrees = ang;
		axis_x = ax;
		axis_y = ay;
		axis_z = az;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_transfer(ang, ax, ay, az);
		@(negedge clk);
	endtask

	function automatic int rand_axis_comp(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom()) >>> $urandom_range(31);
			2: return $signed($urandom_range(7)) - 3;
			default: return 0;
		endcase
	endfunction

	task automatic send_random();
		int ang, mode;
		mode = $urandom_range(9);
		case ($urandom_range(3))
			0: ang = $urandom();
			1: ang = ($signed($urandom_range(16)) - 8) * 32'sd5898240;
			2: ang = ($signed($urandom_range(16)) - 8) * 32'sd5898240
				+ $signed($urandom_range(4)) - 2;
			default: ang = $signed($urandom_range(1440 << 16)) - (720 << 16);
		endcase
		if (mode == 0)
			send_rotation(ang, 0, 0, 0);
		else if (mode < 6)
			send_rotation(ang, $urandom(), $urandom(), $urandom());
		else
			send_rotation(ang, rand_axis_comp($urandom_range(3)),
				rand_axis_comp($urandom_range(3)), rand_axis_comp($urandom_range(3)));
	endtask

	initial begin
		int max_i, min_i;
		max_i = 32'h7fffffff;
		min_i = 32'h80000000;
		arst_n = 1'b0;
		in_valid = 1'b0;
		angle_degrees = 0;
		axis_x = 0;
		axis_y = 0;
		axis_z = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero axis, quadrant boundaries, extreme fields
		send_rotation(0, 0, 0, 0);
		send_rotation(max_i, 0, 0, 0);
		send_rotation(0, 1 << 16, 0, 0);
		send_rotation(90 << 16, 0, 1 << 16, 0);
		send_rotation(180 << 16, 0, 0, 1 << 16);
		send_rotation(270 << 16, 1 << 16, 1 << 16, 1 << 16);
		send_rotation(360 << 16, 1, 0, 0);
		send_rotation(-(90 << 16), 0, 0, -1);
		send_rotation(-(180 << 16), -1, -1, -1);
		send_rotation((90 << 16) + 1, 3, -4, 12);
		send_rotation((90 << 16) - 1, max_i, 0, 0);
		send_rotation(-(90 << 16) - 1, min_i, 0, 0);
		send_rotation((180 << 16) - 1, min_i, min_i, min_i);
		send_rotation(max_i, max_i, max_i, max_i);
		send_rotation(min_i, min_i, max_i, min_i);
		send_rotation(min_i, 1, max_i, -1);
		send_rotation(45 << 16, 0, min_i, 0);
		send_rotation(-1, 0, 0, max_i);
		send_rotation(1, 5, 0, -7);
		send_rotation(30 << 16, 32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 0;  recv_stall_pct = 10; hold_req = 1'b1; end
				2: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				3: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (int n = 0; n < 340; n++) send_random();
		end
		in_valid = 1'b0;

		while (board.pending_mats.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/aar_pkg.sv
rtl/aar_mod_cell.sv
rtl/aar_cordic_cell.sv
rtl/aar_sqrt_cell.sv
rtl/aar_div_cell.sv
rtl/axis_angle_rotation_matrix.sv
sim/tb_axis_angle_rotation_matrix.sv
